// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants
// Opcode and function codes, the decoded instruction record and the data base.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_LH    = 6'h21;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_LHU   = 6'h25;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SH    = 6'h29;
	localparam logic [5:0] OP_SW    = 6'h2B;

	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_SLT = 6'h2A;

	localparam logic [31:0] DATA_BASE = 32'h1000_0000;

	typedef enum logic [1:0] {
		CL_NORMAL,
		CL_ILLEGAL,
		CL_FATAL
	} iclass_t;

	typedef struct packed {
		logic [31:0] instr;
		iclass_t     cls;
		logic        is_mem;
	} dec_t;

endpackage

// ===== hdl/mse_ram.sv =====
// ----------------------------------------------------------------------------
// mse_ram: generic single-port RAM
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/mse_front.sv =====
// ----------------------------------------------------------------------------
// mse_front: instruction accept and classify
// Takes words, classifies them and pushes them into a two-entry queue.
// ----------------------------------------------------------------------------
module mse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [31:0]   instr,
	output logic          q_valid,
	input  logic          q_pop,
	output mse_pkg::dec_t q_head
);

	mse_pkg::dec_t ent_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	mse_pkg::dec_t d;
	logic [5:0]    op;
	logic          push;

	assign op = instr[31:26];

	always_comb begin
		d.instr  = instr;
		d.cls    = mse_pkg::CL_NORMAL;
		d.is_mem = 1'b0;
		if (op == mse_pkg::OP_RTYPE) begin
			unique case (instr[5:0])
				mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_ADD, mse_pkg::FN_SUB,
				mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_SLT: d.cls = mse_pkg::CL_NORMAL;
				default: d.cls = mse_pkg::CL_FATAL;
			endcase
		end else if (op[5:2] == 4'b0100) begin
			d.cls = mse_pkg::CL_FATAL;
		end else begin
			unique case (op)
				mse_pkg::OP_J, mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_ADDI,
				mse_pkg::OP_SLTI, mse_pkg::OP_ANDI, mse_pkg::OP_ORI,
				mse_pkg::OP_LUI, mse_pkg::OP_SW: d.cls = mse_pkg::CL_NORMAL;
				mse_pkg::OP_LB, mse_pkg::OP_LH, mse_pkg::OP_LW, mse_pkg::OP_LBU,
				mse_pkg::OP_LHU, mse_pkg::OP_SB, mse_pkg::OP_SH: d.is_mem = 1'b1;
				default: d.cls = mse_pkg::CL_ILLEGAL;
			endcase
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

// ===== hdl/mse_back.sv =====
// ----------------------------------------------------------------------------
// mse_back: execute unit
// Holds PC, register file and data memory; executes one queued word at a time.
// ----------------------------------------------------------------------------
module mse_back #(
	parameter int DATA_WORDS = 16384
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  mse_pkg::dec_t q_head,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [25:0]   next_pc,
	output logic          reg_write,
	output logic [4:0]    reg_index,
	output logic [31:0]   reg_value,
	output logic          mem_write,
	output logic [13:0]   mem_index,
	output logic [31:0]   mem_value,
	output logic          illegal,
	output logic          halted
);

	localparam int AW = $clog2(DATA_WORDS);

	logic [25:0] pc_q;
	logic [31:0] rf_q [32];
	logic        stop_q;
	logic        wait_q;
	logic        clr_q;
	logic [AW-1:0] clr_idx_q;

	logic [31:0] ins;
	logic [5:0]  op;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] a, b, simm, imm, addr;
	logic [AW-1:0] widx;
	logic [4:0]  bsh, hsh;
	logic [31:0] ram_q, word, bmask, hmask;
	logic        out_free, go, need_wait;

	logic [25:0] npc;
	logic        wr, mw, ill, stp;
	logic [4:0]  wi;
	logic [31:0] wv, mv;

	assign ins  = q_head.instr;
	assign op   = ins[31:26];
	assign rs   = ins[25:21];
	assign rt   = ins[20:16];
	assign rd   = ins[15:11];
	assign sa   = ins[10:6];
	assign imm  = {16'h0, ins[15:0]};
	assign simm = {{16{ins[15]}}, ins[15:0]};
	assign a    = (rs == 5'd0) ? 32'h0 : rf_q[rs];
	assign b    = (rt == 5'd0) ? 32'h0 : rf_q[rt];
	assign addr = a + simm - mse_pkg::DATA_BASE;
	assign widx = addr[AW+1:2];
	assign bsh  = {~addr[1:0], 3'b000};
	assign hsh  = addr[1] ? 5'd0 : 5'd16;
	assign word = ram_q;
	assign bmask = 32'hFF << bsh;
	assign hmask = 32'hFFFF << hsh;

	// Memory-reading words first wait for the registered data memory read (wait_q).
	// Nothing executes while the fill pass after reset is still running.
	assign need_wait = q_head.is_mem && !stop_q && !wait_q;
	assign out_free  = !out_valid || out_ready;
	assign go        = q_valid && out_free && !need_wait && !clr_q;
	assign q_pop     = go;

	always_comb begin
		npc = pc_q + 26'd1;
		wr = 1'b0; mw = 1'b0; ill = 1'b0; stp = stop_q;
		wi = 5'd0; wv = 32'h0; mv = 32'h0;
		if (stop_q) begin
			npc = pc_q;
		end else if (q_head.cls == mse_pkg::CL_FATAL) begin
			ill = 1'b1; stp = 1'b1; npc = pc_q;
		end else if (q_head.cls == mse_pkg::CL_ILLEGAL) begin
			ill = 1'b1;
		end else if (op == mse_pkg::OP_RTYPE) begin
			wr = 1'b1; wi = rd;
			case (ins[5:0])
				mse_pkg::FN_ADD: wv = a + b;
				mse_pkg::FN_SUB: wv = a - b;
				mse_pkg::FN_AND: wv = a & b;
				mse_pkg::FN_OR:  wv = a | b;
				mse_pkg::FN_SLT: wv = {31'h0, $signed(a) < $signed(b)};
				mse_pkg::FN_SLL: wv = b << sa;
				default:         wv = b >> sa;
			endcase
		end else begin
			wi = rt;
			case (op)
				mse_pkg::OP_J:    npc = ins[25:0];
				mse_pkg::OP_ADDI: begin wr = 1'b1; wv = a + simm; end
				mse_pkg::OP_ANDI: begin wr = 1'b1; wv = a & imm; end
				mse_pkg::OP_ORI:  begin wr = 1'b1; wv = a | imm; end
				mse_pkg::OP_LUI:  begin wr = 1'b1; wv = {ins[15:0], 16'h0}; end
				mse_pkg::OP_SLTI: begin
					wr = 1'b1; wv = {31'h0, $signed(a) < $signed(simm)};
				end
				mse_pkg::OP_BEQ:  if (a == b) npc = pc_q + 26'd1 + simm[25:0];
				mse_pkg::OP_BNE:  if (a != b) npc = pc_q + 26'd1 + simm[25:0];
				mse_pkg::OP_LW:   begin wr = 1'b1; wv = word; end
				mse_pkg::OP_LB:   begin
					wr = 1'b1; wv = {{24{word[bsh+5'd7]}}, word[bsh +: 8]};
				end
				mse_pkg::OP_LBU:  begin wr = 1'b1; wv = {24'h0, word[bsh +: 8]}; end
				mse_pkg::OP_LH:   begin
					wr = 1'b1; wv = {{16{word[hsh+5'd15]}}, word[hsh +: 16]};
				end
				mse_pkg::OP_LHU:  begin wr = 1'b1; wv = {16'h0, word[hsh +: 16]}; end
				mse_pkg::OP_SW:   begin mw = 1'b1; mv = b; end
				mse_pkg::OP_SB:   begin
					mw = 1'b1; mv = (word & ~bmask) | ({24'h0, b[7:0]} << bsh);
				end
				default: begin
					mw = 1'b1; mv = (word & ~hmask) | ({16'h0, b[15:0]} << hsh);
				end
			endcase
		end
		if (wi == 5'd0)
			wr = 1'b0;
		if (!wr) begin
			wi = 5'd0; wv = 32'h0;
		end
	end

	mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (clr_q || (go && mw)),
		.addr  (clr_q ? clr_idx_q : widx),
		.wdata (clr_q ? 32'hFFFF_FFFF : mv),
		.rdata (ram_q)
	);

	always_ff @(posedge clk) begin
		if (go) begin
			next_pc   <= npc;
			reg_write <= wr;
			reg_index <= wi;
			reg_value <= wv;
			mem_write <= mw;
			mem_index <= mw ? 14'(widx) : 14'd0;
			mem_value <= mv;
			illegal   <= ill;
			halted    <= stp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 26'd0;
			stop_q    <= 1'b0;
			wait_q    <= 1'b0;
			out_valid <= 1'b0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			for (int i = 0; i < 32; i++)
				rf_q[i] <= 32'h0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(DATA_WORDS - 1))
					clr_q <= 1'b0;
			end
			if (go && wr)
				rf_q[wi] <= wv;
			if (go) begin
				pc_q   <= npc;
				stop_q <= stp;
			end
			wait_q <= need_wait && q_valid && !clr_q;
			if (go)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q && go |=> pc_q == $past(pc_q)) else $error("PC moved after halt");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q) else $error("halt cleared");
	a_mem_waits: assert property (@(posedge clk) disable iff (!arst_n)
		go && q_head.is_mem && !stop_q |-> wait_q) else $error("load without fetch");

endmodule

// ===== hdl/mips_subset_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// An accepted word waits in the front queue; its result is registered when the
// back end executes it, after the data memory read for loads and partial
// stores. Throughput: one word per cycle while out_ready holds; memory words
// wait for their read. Reset (arst_n low) clears PC, registers and halt at
// once; a fill pass sets every memory word to all ones before any executes.
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor: MIPS32 subset executor
// Front end classifies words into a queue; back end executes them in order.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
	parameter int DATA_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [25:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_write,
	output logic [13:0] mem_index,
	output logic [31:0] mem_value,
	output logic        illegal,
	output logic        halted
);

	logic          q_valid, q_pop;
	mse_pkg::dec_t q_head;

	mse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.instr(instr), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	mse_back #(.DATA_WORDS(DATA_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .reg_write(reg_write), .reg_index(reg_index),
		.reg_value(reg_value), .mem_write(mem_write), .mem_index(mem_index),
		.mem_value(mem_value), .illegal(illegal), .halted(halted)
	);

endmodule

// ===== tb/sv/mips_subset_instruction_executor_test.sv =====
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor_test: self-checking bench for the executor
// Drives instruction words through the valid/ready input, keeps its own model
// of PC, registers and data memory, and checks every result word in order.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor_test;

	localparam int DATA_WORDS  = 16384;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [25:0] next_pc;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [13:0] mem_index;
		logic [31:0] mem_value;
		logic        illegal;
		logic        halted;
	} exec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instr;
	logic        out_valid;
	logic        out_ready;
	logic [25:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_write;
	logic [13:0] mem_index;
	logic [31:0] mem_value;
	logic        illegal;
	logic        halted;

	mips_subset_instruction_executor #(.DATA_WORDS(DATA_WORDS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .instr(instr),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .reg_write(reg_write), .reg_index(reg_index),
		.reg_value(reg_value), .mem_write(mem_write), .mem_index(mem_index),
		.mem_value(mem_value), .illegal(illegal), .halted(halted)
	);

	always #10 clk = ~clk;

	// Architectural state as the executor should see it.
	logic [25:0] pc_model;
	logic [31:0] gpr [32];
	logic [31:0] dmem [DATA_WORDS];
	logic        halt_model;

	exec_t exec_q[$];
	int    mismatches = 0;
	int    words_sent = 0;
	int    results_seen = 0;
	int    cycles = 0;
	int    burst_left = 0;
	int    gap_left = 0;
	bit    hold_req = 1'b0;
	int    hold_cnt = 0;
	int    rx_mode = 0;
	int    rx_left = 0;

	localparam logic [5:0] WF_OPS [23] = '{
		mse_pkg::OP_RTYPE, mse_pkg::OP_RTYPE, mse_pkg::OP_RTYPE, mse_pkg::OP_RTYPE,
		mse_pkg::OP_RTYPE, mse_pkg::OP_RTYPE, mse_pkg::OP_RTYPE,
		mse_pkg::OP_ADDI, mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_LUI,
		mse_pkg::OP_SLTI, mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_J,
		mse_pkg::OP_LW, mse_pkg::OP_SW, mse_pkg::OP_LB, mse_pkg::OP_LBU,
		mse_pkg::OP_LH, mse_pkg::OP_LHU, mse_pkg::OP_SB, mse_pkg::OP_SH
	};
	localparam logic [5:0] R_FNS [7] = '{
		mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_AND, mse_pkg::FN_OR,
		mse_pkg::FN_SLT, mse_pkg::FN_SLL, mse_pkg::FN_SRL
	};

	function automatic bit rfn_known(logic [5:0] fn);
		case (fn)
			mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_AND, mse_pkg::FN_OR,
			mse_pkg::FN_SLT, mse_pkg::FN_SLL, mse_pkg::FN_SRL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_fatal(logic [31:0] w);
		return (w[31:26] == mse_pkg::OP_RTYPE && !rfn_known(w[5:0])) ||
			w[31:28] == 4'b0100;
	endfunction

	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sa);
		return {mse_pkg::OP_RTYPE, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic void reset_model();
		pc_model = '0;
		halt_model = 1'b0;
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem[i]) dmem[i] = '1;
	endfunction

	// Executes one word against the model state and returns the result word.
	function automatic exec_t execute_word(logic [31:0] w);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sa, bsh, hsh;
		logic [31:0] simm, a, b, addr, word, wv, mv;
		logic [13:0] widx;
		logic [7:0]  byt;
		logic [15:0] half;
		logic        wr, mw;
		exec_t       r;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sa = w[10:6]; fn = w[5:0];
		simm = {{16{w[15]}}, w[15:0]};
		a = gpr[rs]; b = gpr[rt];
		addr = a + simm - mse_pkg::DATA_BASE;
		widx = addr[15:2];
		word = dmem[widx];
		bsh = (5'd3 - {3'd0, addr[1:0]}) * 5'd8;
		hsh = addr[1] ? 5'd0 : 5'd16;
		byt = 8'(word >> bsh);
		half = 16'(word >> hsh);
		r = '0;
		wr = 1'b0; mw = 1'b0; wv = '0; mv = '0;
		r.next_pc = pc_model + 26'd1;
		if (halt_model) begin
			r.next_pc = pc_model;
		end else if (op == mse_pkg::OP_RTYPE) begin
			wr = 1'b1; r.reg_index = rd;
			case (fn)
				mse_pkg::FN_ADD: wv = a + b;
				mse_pkg::FN_SUB: wv = a - b;
				mse_pkg::FN_AND: wv = a & b;
				mse_pkg::FN_OR:  wv = a | b;
				mse_pkg::FN_SLT: wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				mse_pkg::FN_SLL: wv = b << sa;
				mse_pkg::FN_SRL: wv = b >> sa;
				default: begin
					wr = 1'b0; r.illegal = 1'b1; halt_model = 1'b1;
					r.next_pc = pc_model;
				end
			endcase
		end else if (op[5:2] == 4'b0100) begin
			r.illegal = 1'b1; halt_model = 1'b1; r.next_pc = pc_model;
		end else begin
			r.reg_index = rt;
			case (op)
				mse_pkg::OP_J:    r.next_pc = w[25:0];
				mse_pkg::OP_ADDI: begin wr = 1'b1; wv = a + simm; end
				mse_pkg::OP_ANDI: begin wr = 1'b1; wv = a & {16'd0, w[15:0]}; end
				mse_pkg::OP_ORI:  begin wr = 1'b1; wv = a | {16'd0, w[15:0]}; end
				mse_pkg::OP_LUI:  begin wr = 1'b1; wv = {w[15:0], 16'd0}; end
				mse_pkg::OP_SLTI: begin
					wr = 1'b1; wv = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
				end
				mse_pkg::OP_BEQ:  if (a == b) r.next_pc = pc_model + 26'd1 + simm[25:0];
				mse_pkg::OP_BNE:  if (a != b) r.next_pc = pc_model + 26'd1 + simm[25:0];
				mse_pkg::OP_LW:   begin wr = 1'b1; wv = word; end
				mse_pkg::OP_LB:   begin wr = 1'b1; wv = {{24{byt[7]}}, byt}; end
				mse_pkg::OP_LBU:  begin wr = 1'b1; wv = {24'd0, byt}; end
				mse_pkg::OP_LH:   begin wr = 1'b1; wv = {{16{half[15]}}, half}; end
				mse_pkg::OP_LHU:  begin wr = 1'b1; wv = {16'd0, half}; end
				mse_pkg::OP_SW:   begin mw = 1'b1; mv = b; end
				mse_pkg::OP_SB:   begin
					mw = 1'b1;
					mv = (word & ~(32'hFF << bsh)) | ({24'd0, b[7:0]} << bsh);
				end
				mse_pkg::OP_SH:   begin
					mw = 1'b1;
					mv = (word & ~(32'hFFFF << hsh)) | ({16'd0, b[15:0]} << hsh);
				end
				default: r.illegal = 1'b1;
			endcase
			if (mw) begin
				r.mem_write = 1'b1; r.mem_index = widx; r.mem_value = mv;
				dmem[widx] = mv;
			end
		end
		if (wr && r.reg_index != 5'd0) begin
			r.reg_write = 1'b1; r.reg_value = wv;
			gpr[r.reg_index] = wv;
		end else begin
			r.reg_index = '0;
		end
		pc_model = r.next_pc;
		r.halted = halt_model;
		return r;
	endfunction

	// A supported instruction with random fields; memory words mostly use the
	// base held in r28 so that loads see earlier stores.
	function automatic logic [31:0] random_legal();
		logic [5:0]  op;
		logic [4:0]  rs, rt;
		logic [15:0] imm;
		op = WF_OPS[$urandom_range(0, 22)];
		rs = 5'($urandom_range(0, 31));
		rt = 5'($urandom_range(0, 31));
		imm = 16'($urandom);
		if (op == mse_pkg::OP_RTYPE) begin
			if (rt == 5'd28 && $urandom_range(0, 1)) rt = 5'd1;
			return enc_r(R_FNS[$urandom_range(0, 6)], rs, rt,
				($urandom_range(0, 31) == 28) ? 5'd27 : 5'($urandom_range(0, 31)),
				5'($urandom_range(0, 31)));
		end
		if (op == mse_pkg::OP_J) return {op, 26'($urandom)};
		if (op[5] && $urandom_range(0, 9) < 7) begin
			rs = 5'd28;
			imm = 16'($signed($urandom_range(0, 127)) - 64);
		end
		if (rt == 5'd28 && !(op == mse_pkg::OP_SW || op == mse_pkg::OP_SB ||
				op == mse_pkg::OP_SH || op == mse_pkg::OP_BEQ ||
				op == mse_pkg::OP_BNE)) rt = 5'd27;
		return enc_i(op, rs, rt, imm);
	endfunction

	function automatic logic [31:0] random_noise();
		logic [31:0] w;
		do w = $urandom; while (is_fatal(w));
		return w;
	endfunction

	task automatic send_word(logic [31:0] w);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap_left = $urandom_range(0, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(negedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		instr <= w;
		do @(posedge clk); while (!in_ready);
		exec_q.push_back(execute_word(w));
		words_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (exec_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_alu();
		send_word(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
		send_word(enc_i(mse_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));
		send_word(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd2, 16'h7FFF));
		send_word(enc_i(mse_pkg::OP_ORI, 5'd2, 5'd2, 16'hFFFF));
		send_word(enc_r(mse_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));
		send_word(enc_r(mse_pkg::FN_ADD, 5'd2, 5'd2, 5'd3, 5'd0));
		send_word(enc_r(mse_pkg::FN_SUB, 5'd1, 5'd2, 5'd4, 5'd0));
		send_word(enc_r(mse_pkg::FN_AND, 5'd1, 5'd2, 5'd5, 5'd0));
		send_word(enc_r(mse_pkg::FN_OR,  5'd1, 5'd2, 5'd6, 5'd0));
		send_word(enc_r(mse_pkg::FN_SLT, 5'd1, 5'd2, 5'd7, 5'd0));
		send_word(enc_r(mse_pkg::FN_SLT, 5'd2, 5'd1, 5'd7, 5'd0));
		send_word(enc_r(mse_pkg::FN_SLL, 5'd0, 5'd2, 5'd8, 5'd31));
		send_word(enc_r(mse_pkg::FN_SLL, 5'd0, 5'd1, 5'd8, 5'd0));
		send_word(enc_r(mse_pkg::FN_SRL, 5'd0, 5'd1, 5'd9, 5'd31));
		send_word(enc_i(mse_pkg::OP_ADDI, 5'd2, 5'd10, 16'h0001));
		send_word(enc_i(mse_pkg::OP_ADDI, 5'd0, 5'd10, 16'hFFFF));
		send_word(enc_i(mse_pkg::OP_ANDI, 5'd1, 5'd11, 16'hFFFF));
		send_word(enc_i(mse_pkg::OP_SLTI, 5'd1, 5'd12, 16'hFFFF));
		send_word(enc_i(mse_pkg::OP_SLTI, 5'd0, 5'd12, 16'h7FFF));
		send_word(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd13, 16'hFFFF));
		// Writes aimed at register zero must vanish.
		send_word(enc_r(mse_pkg::FN_ADD, 5'd1, 5'd2, 5'd0, 5'd0));
		send_word(enc_i(mse_pkg::OP_ADDI, 5'd1, 5'd0, 16'h1234));
		send_word(enc_r(mse_pkg::FN_OR, 5'd0, 5'd0, 5'd14, 5'd0));
		wait_drain();
	endtask

	task automatic test_control();
		send_word(enc_i(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'h0005));
		send_word(enc_i(mse_pkg::OP_BEQ, 5'd1, 5'd2, 16'h7FFF));
		send_word(enc_i(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'hFFF8));
		send_word(enc_i(mse_pkg::OP_BNE, 5'd0, 5'd0, 16'h0010));
		send_word({mse_pkg::OP_J, 26'h3FFFFFF});
		send_word(enc_i(mse_pkg::OP_BEQ, 5'd3, 5'd3, 16'h7FFF));
		send_word(enc_i(mse_pkg::OP_BNE, 5'd1, 5'd0, 16'h8000));
		send_word({mse_pkg::OP_J, 26'h0000000});
		send_word({6'h03, 26'h1555555});
		send_word({6'h3F, 26'h3FFFFFF});
		send_word({6'h01, 26'h2AAAAAA});
		wait_drain();
	endtask

	task automatic test_memory();
		int i;
		send_word(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd28, 16'h1000));
		send_word(enc_i(mse_pkg::OP_LW, 5'd28, 5'd5, 16'h0100));
		send_word(enc_i(mse_pkg::OP_SW, 5'd28, 5'd1, 16'h0003));
		send_word(enc_i(mse_pkg::OP_LW, 5'd28, 5'd5, 16'h0000));
		for (i = 0; i < 4; i++) begin
			send_word(enc_i(mse_pkg::OP_LB, 5'd28, 5'd15, 16'(i)));
			send_word(enc_i(mse_pkg::OP_LBU, 5'd28, 5'd16, 16'(i)));
			send_word(enc_i(mse_pkg::OP_LH, 5'd28, 5'd17, 16'(i)));
			send_word(enc_i(mse_pkg::OP_LHU, 5'd28, 5'd18, 16'(i)));
		end
		send_word(enc_i(mse_pkg::OP_SB, 5'd28, 5'd2, 16'h0001));
		send_word(enc_i(mse_pkg::OP_SB, 5'd28, 5'd1, 16'h0003));
		send_word(enc_i(mse_pkg::OP_SH, 5'd28, 5'd2, 16'h0003));
		send_word(enc_i(mse_pkg::OP_SH, 5'd28, 5'd1, 16'h0000));
		send_word(enc_i(mse_pkg::OP_LW, 5'd28, 5'd5, 16'h0000));
		// Base zero wraps far past the top of the data space.
		send_word(enc_i(mse_pkg::OP_SW, 5'd0, 5'd2, 16'hFFFC));
		send_word(enc_i(mse_pkg::OP_LW, 5'd0, 5'd19, 16'hFFFF));
		send_word(enc_i(mse_pkg::OP_SB, 5'd28, 5'd2, 16'h8000));
		send_word(enc_i(mse_pkg::OP_LHU, 5'd28, 5'd20, 16'h8001));
		wait_drain();
	endtask

	task automatic test_random(int count);
		repeat (count) send_word(($urandom_range(0, 99) < 85) ? random_legal()
			: random_noise());
		wait_drain();
	endtask

	// The receiver stops for a long stretch while words keep coming in.
	task automatic test_backpressure();
		hold_req = 1'b1;
		burst_left = 64;
		gap_left = 0;
		repeat (48) send_word(random_legal());
		wait_drain();
	endtask

	task automatic test_halt();
		logic [31:0] w;
		if ($urandom_range(0, 1)) begin
			do w = $urandom; while (rfn_known(w[5:0]));
			w[31:26] = mse_pkg::OP_RTYPE;
		end else begin
			w = $urandom;
			w[31:28] = 4'b0100;
		end
		send_word(w);
		repeat (6) send_word(random_legal());
		send_word(random_noise());
		wait_drain();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			out_ready <= 1'b0;
			hold_cnt++;
			if (hold_cnt >= HOLD_CYCLES) begin
				hold_req = 1'b0;
				hold_cnt = 0;
			end
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		exec_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{next_pc, reg_write, reg_index, reg_value, mem_write, mem_index,
				mem_value, illegal, halted};
			results_seen++;
			if (exec_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: %p", got);
			end else begin
				want = exec_q.pop_front();
				if (got.next_pc != want.next_pc || got.reg_write != want.reg_write ||
						got.reg_index != want.reg_index ||
						got.reg_value != want.reg_value ||
						got.mem_write != want.mem_write ||
						got.mem_index != want.mem_index ||
						got.mem_value != want.mem_value ||
						got.illegal != want.illegal || got.halted != want.halted) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch\n  expected %p\n  actual   %p",
							results_seen, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, exec_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		instr = '0;
		out_ready = 1'b0;
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_alu();
		test_control();
		test_memory();
		test_random(600);
		test_backpressure();
		test_random(650);
		test_halt();
		$display("%0d words sent, %0d results checked: ALU, branch, jump, loads, stores,",
			words_sent, results_seen);
		$display("illegal words, receiver hold-off and a fatal halt were exercised");
		if (mismatches == 0 && exec_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/mse_front.sv
hdl/mse_back.sv
hdl/mips_subset_instruction_executor.sv
tb/sv/mips_subset_instruction_executor_test.sv
